>>> rtl/hmtp_pkg.sv
package hmtp_pkg;

  // default sizes of the saturating position counters
  localparam int unsigned DEF_MAX_COLUMNS = 1024;
  localparam int unsigned DEF_MAX_ROWS    = 1024;

  // reset value of the default color register
  localparam logic [31:0] DEF_COLOR = 32'h00FF_FFFF;

  // fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned INDEX_W = 20;
  localparam int unsigned VAL_W   = 32;

  // characters the parser reacts to
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LOW_X   = 8'h78;

  // token parse modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SIGN   = 3'd1,
    MODE_HEIGHT = 3'd2,
    MODE_COMMA  = 3'd3,
    MODE_ZERO   = 3'd4,
    MODE_HEX    = 3'd5,
    MODE_BAD    = 3'd6
  } mode_t;

  // hex digit decode result
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.ok = 1'b1;
    end else if ((c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      h.ok  = 1'b1;
      h.val = 4'(c[3:0] + 4'd9);
    end
    return h;
  endfunction

endpackage

>>> rtl/height_map_token_parser_core.sv
// Height-map token parser core.
// The input channel (in_valid / in_stall) takes one character of map text per
// transaction, with in_end_of_input marking the last byte of the file. Tokens
// are a signed decimal height, optionally followed by ",", an optional "0x"
// and hex color digits; a space, newline or end of input closes a token and
// yields one result transaction on out_valid / out_stall carrying column, row,
// point index, height, color and a format error flag.
// The cfg port writes the default color used for tokens without a color part;
// cfg_ready is always high. The user must make writes only while the block
// is idle; the block does not enforce this. A byte passes the input register,
// then the parse step into the result register. One byte is taken every
// cycle while in_stall is low; the limit is the update of the token state
// (multiply by ten plus digit, then negate) feeding the result register.
// When the receiver stalls, the result register holds its transaction, the
// parse step waits and in_stall rises once the input register is also full.
// Synchronous active-low reset clears the parse state, position counters and
// both valid flags, and sets the default color to 0x00FFFFFF.
module height_map_token_parser_core
  import hmtp_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_text_byte,
  input  logic                     in_end_of_input,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [POS_W-1:0]         out_column,
  output logic [POS_W-1:0]         out_row,
  output logic [INDEX_W-1:0]       out_point_index,
  output logic signed [VAL_W-1:0]  out_height,
  output logic [VAL_W-1:0]         out_color,
  output logic                     out_format_error,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [VAL_W-1:0]         cfg_default_color
);

  localparam int unsigned COL_W = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_eoi_r;

  // token and position state
  mode_t               mode_r, mode_nxt;
  logic [VAL_W-1:0]    hacc_r, hacc_nxt;
  logic                neg_r, neg_nxt;
  logic [VAL_W-1:0]    cacc_r, cacc_nxt;
  logic                has_color_r, has_color_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [INDEX_W-1:0]  point_r, point_nxt;
  logic [VAL_W-1:0]    dcolor_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]    ocol_r;
  logic [ROW_W-1:0]    orow_r;
  logic [INDEX_W-1:0]  opoint_r;
  logic [VAL_W-1:0]    oheight_r;
  logic [VAL_W-1:0]    ocolor_r;
  logic                oerr_r;

  // step control
  logic                in_accept;
  logic                advance;
  logic                step;
  logic                emit;
  logic                delim;
  logic                is_dec;
  logic                is_newline;
  hex_t                hx;
  mode_t               mode_step;
  logic [VAL_W-1:0]    hacc_step;
  logic [VAL_W-1:0]    cacc_step;
  logic                neg_step;
  logic                has_color_step;
  logic [VAL_W-1:0]    height_val;
  logic [COL_W+POS_W-1:0] col_ext;
  logic [ROW_W+POS_W-1:0] row_ext;

  // handshakes
  assign advance   = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // character classes
  assign is_newline = (s1_byte_r == CH_NEWLINE);
  assign delim      = (s1_byte_r == CH_SPACE) || is_newline;
  assign is_dec     = (s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE);
  assign hx         = hex_digit(s1_byte_r);

  // token mode update for one character
  always_comb begin
    mode_step      = mode_r;
    hacc_step      = hacc_r;
    cacc_step      = cacc_r;
    neg_step       = neg_r;
    has_color_step = has_color_r;
    if (!delim) begin
      case (mode_r)
        MODE_IDLE: begin
          if (s1_byte_r == CH_MINUS) begin
            neg_step  = 1'b1;
            mode_step = MODE_SIGN;
          end else if (is_dec) begin
            hacc_step = VAL_W'(s1_byte_r[3:0]);
            mode_step = MODE_HEIGHT;
          end else begin
            mode_step = MODE_BAD;
          end
        end
        MODE_SIGN, MODE_HEIGHT: begin
          if (is_dec) begin
            hacc_step = (hacc_r << 3) + (hacc_r << 1) + VAL_W'(s1_byte_r[3:0]);
            mode_step = MODE_HEIGHT;
          end else if (s1_byte_r == CH_COMMA && mode_r == MODE_HEIGHT) begin
            has_color_step = 1'b1;
            cacc_step      = '0;
            mode_step      = MODE_COMMA;
          end else begin
            mode_step = MODE_BAD;
          end
        end
        MODE_COMMA: begin
          if (s1_byte_r == CH_ZERO) begin
            mode_step = MODE_ZERO;
          end else if (hx.ok) begin
            cacc_step = {cacc_r[VAL_W-5:0], hx.val};
            mode_step = MODE_HEX;
          end else begin
            mode_step = MODE_BAD;
          end
        end
        MODE_ZERO: begin
          if (s1_byte_r == CH_LOW_X) begin
            mode_step = MODE_HEX;
          end else if (hx.ok) begin
            cacc_step = {cacc_r[VAL_W-5:0], hx.val};
            mode_step = MODE_HEX;
          end else begin
            mode_step = MODE_BAD;
          end
        end
        MODE_HEX: begin
          if (hx.ok) begin
            cacc_step = {cacc_r[VAL_W-5:0], hx.val};
          end else begin
            mode_step = MODE_BAD;
          end
        end
        default: begin
          mode_step = MODE_BAD;
        end
      endcase
    end
  end

  // token close, counters and next state
  assign emit       = (delim || s1_eoi_r) && (mode_step != MODE_IDLE);
  assign height_val = neg_step ? (VAL_W'(0) - hacc_step) : hacc_step;

  always_comb begin
    mode_nxt      = mode_r;
    hacc_nxt      = hacc_r;
    neg_nxt       = neg_r;
    cacc_nxt      = cacc_r;
    has_color_nxt = has_color_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    point_nxt     = point_r;
    if (step) begin
      mode_nxt      = mode_step;
      hacc_nxt      = hacc_step;
      neg_nxt       = neg_step;
      cacc_nxt      = cacc_step;
      has_color_nxt = has_color_step;
      if (emit) begin
        mode_nxt      = MODE_IDLE;
        hacc_nxt      = '0;
        neg_nxt       = 1'b0;
        cacc_nxt      = '0;
        has_color_nxt = 1'b0;
        point_nxt     = point_r + 1'b1;
        if (col_r < COL_LAST) begin
          col_nxt = col_r + 1'b1;
        end
      end
      if (is_newline) begin
        col_nxt = '0;
        if (row_r < ROW_LAST) begin
          row_nxt = row_r + 1'b1;
        end
      end
    end
  end

  // valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_IDLE;
      hacc_r      <= '0;
      neg_r       <= 1'b0;
      cacc_r      <= '0;
      has_color_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      point_r     <= '0;
      dcolor_r    <= DEF_COLOR;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      hacc_r      <= hacc_nxt;
      neg_r       <= neg_nxt;
      cacc_r      <= cacc_nxt;
      has_color_r <= has_color_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      point_r     <= point_nxt;
      if (cfg_valid && cfg_ready) begin
        dcolor_r <= cfg_default_color;
      end
    end
  end

  // input and result payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_text_byte;
      s1_eoi_r  <= in_end_of_input;
    end
    if (step && emit) begin
      ocol_r    <= col_r;
      orow_r    <= row_r;
      opoint_r  <= point_r;
      oheight_r <= height_val;
      ocolor_r  <= has_color_step ? cacc_step : dcolor_r;
      oerr_r    <= (mode_step == MODE_BAD) || (mode_step == MODE_SIGN);
    end
  end

  // result ports, positions masked to the field width
  assign col_ext          = {{POS_W{1'b0}}, ocol_r};
  assign row_ext          = {{POS_W{1'b0}}, orow_r};
  assign out_valid        = out_valid_r;
  assign out_column       = col_ext[POS_W-1:0];
  assign out_row          = row_ext[POS_W-1:0];
  assign out_point_index  = opoint_r;
  assign out_height       = oheight_r;
  assign out_color        = ocolor_r;
  assign out_format_error = oerr_r;

  // checks
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> mode_r == MODE_IDLE)
    else $error("parse mode not idle after reset");

  a_col_sat: assert property (@(posedge clk) disable iff (!rst_n) col_r <= COL_LAST)
    else $error("column counter beyond saturation");

  a_row_sat: assert property (@(posedge clk) disable iff (!rst_n) row_r <= ROW_LAST)
    else $error("row counter beyond saturation");

  a_point_step: assert property (@(posedge clk) disable iff (!rst_n)
      (step && emit) |=> point_r == $past(point_r) + 1'b1)
    else $error("point index did not advance with a result");

  a_sign_mode: assert property (@(posedge clk) disable iff (!rst_n)
      neg_r |-> mode_r != MODE_IDLE)
    else $error("sign held with no open token");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
      in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

endmodule
